// ----- sv/assert_macros.svh -----
// Assertion macros used by the deframer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- sv/sldf_pkg.sv -----
// Shared types and constants of the sync, length and checksum deframer.
package sldf_pkg;

  localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [1:0] REG_SYNC2_DATA  = 2'd1;
  localparam logic [1:0] REG_SYNC2_ACK   = 2'd2;

  localparam logic [7:0] FIRST_SYNC_RST  = 8'h55;
  localparam logic [7:0] SYNC2_DATA_RST  = 8'h55;
  localparam logic [7:0] SYNC2_ACK_RST   = 8'hAF;

  typedef struct packed {
    logic sum_init;
    logic sum_add;
    logic kind_set;
    logic id_load;
    logic len_load;
    logic data_take;
    logic emit_clr;
    logic emit_inc;
    logic out_data;
    logic out_zero;
  } sldf_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic sync2_ok;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic sum_match;
    logic held_len_zero;
    logic emit_last;
    logic out_free;
  } sldf_sts_t;

endpackage

// ----- sv/sldf_ctrl.sv -----
// Controller state machine that sequences framing and result emission.
`include "assert_macros.svh"

module sldf_ctrl
  import sldf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sldf_sts_t sts,
  output sldf_cmd_t cmd
);

  localparam logic [3:0] S_SYNC1 = 4'd0;
  localparam logic [3:0] S_SYNC2 = 4'd1;
  localparam logic [3:0] S_ID    = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_DATA  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_ZERO  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_SYNC1) || (state_r == S_SYNC2) || (state_r == S_ID) ||
                    (state_r == S_LEN) || (state_r == S_DATA) || (state_r == S_SUM);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_SYNC1: begin
        if (acc) begin
          cmd.sum_init = 1'b1;
          state_nxt    = sts.is_sync1 ? S_SYNC2 : S_SYNC1;
        end
      end
      S_SYNC2: begin
        if (acc) begin
          cmd.sum_add = 1'b1;
          if (sts.sync2_ok) begin
            cmd.kind_set = 1'b1;
            state_nxt    = S_ID;
          end else begin
            state_nxt = S_SYNC1;
          end
        end
      end
      S_ID: begin
        if (acc) begin
          cmd.id_load = 1'b1;
          cmd.sum_add = 1'b1;
          state_nxt   = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          if (sts.len_ok) begin
            cmd.len_load = 1'b1;
            cmd.sum_add  = 1'b1;
            state_nxt    = sts.len_zero ? S_SUM : S_DATA;
          end else begin
            state_nxt = S_SYNC1;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.data_take = 1'b1;
          cmd.sum_add   = 1'b1;
          if (sts.data_done) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (acc) begin
          if (sts.sum_match) begin
            cmd.emit_clr = 1'b1;
            state_nxt    = sts.held_len_zero ? S_ZERO : S_RD;
          end else begin
            state_nxt = S_SYNC1;
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_data = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_SYNC1;
          end else begin
            cmd.emit_inc = 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.out_zero = 1'b1;
          state_nxt    = S_SYNC1;
        end
      end
      default: begin
        state_nxt = S_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CHECK_NEXT(a_out_stall_holds, (state_r == S_OUT) && !sts.out_free, state_r == S_OUT)
  `CHECK_NEXT(a_bad_sum_hunts, (state_r == S_SUM) && acc && !sts.sum_match, state_r == S_SYNC1)
  `CHECK_NEXT(a_bad_len_hunts, (state_r == S_LEN) && acc && !sts.len_ok, state_r == S_SYNC1)
  `CHECK_SAME(a_emit_blocks_input, cmd.out_data || cmd.out_zero, !in_ready)

endmodule

// ----- sv/sldf_dp.sv -----
// Datapath with frame registers, checksum, payload memory and result register.
module sldf_dp
  import sldf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  first_sync,
  input  logic [7:0]  second_sync_data,
  input  logic [7:0]  second_sync_ack,
  input  sldf_cmd_t   cmd,
  output sldf_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_done,
  output logic        out_frame_kind_ack,
  output logic [7:0]  out_message_id,
  output logic [5:0]  out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_byte_position,
  output logic        out_last_of_frame
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
  localparam logic [6:0] MaxTaken = 7'(MAX_PAYLOAD);

  logic [7:0] sum_r;
  logic [7:0] id_r;
  logic [5:0] len_r;
  logic [5:0] taken_r;
  logic [5:0] taken_nxt;
  logic       kind_r;
  logic [5:0] emit_idx_r;
  logic [7:0] rdata_r;
  logic [7:0] mem [MAX_PAYLOAD];

  logic       out_valid_r;
  logic       done_r;
  logic       okind_r;
  logic [7:0] oid_r;
  logic [5:0] olen_r;
  logic [7:0] obyte_r;
  logic [4:0] opos_r;
  logic       olast_r;

  assign taken_nxt = taken_r + 6'd1;

  assign sts.is_sync1      = (in_rx_byte == first_sync);
  assign sts.sync2_ok      = (in_rx_byte == second_sync_ack) || (in_rx_byte == second_sync_data);
  assign sts.len_ok        = (in_rx_byte <= MaxLen);
  assign sts.len_zero      = (in_rx_byte == 8'd0);
  assign sts.data_done     = (taken_nxt >= len_r);
  assign sts.sum_match     = (sum_r == in_rx_byte);
  assign sts.held_len_zero = (len_r == 6'd0);
  assign sts.emit_last     = (({1'b0, emit_idx_r} + 7'd1) == {1'b0, len_r});
  assign sts.out_free      = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      sum_r <= in_rx_byte;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + in_rx_byte;
    end
    if (cmd.kind_set) begin
      kind_r <= (in_rx_byte == second_sync_ack);
    end
    if (cmd.id_load) begin
      id_r <= in_rx_byte;
    end
    if (cmd.len_load) begin
      len_r   <= in_rx_byte[5:0];
      taken_r <= 6'd0;
    end else if (cmd.data_take) begin
      taken_r <= taken_nxt;
    end
    if (cmd.emit_clr) begin
      emit_idx_r <= 6'd0;
    end else if (cmd.emit_inc) begin
      emit_idx_r <= emit_idx_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_take && ({1'b0, taken_r} < MaxTaken)) begin
      mem[taken_r[AW-1:0]] <= in_rx_byte;
    end
    rdata_r <= mem[emit_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_data || cmd.out_zero) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_data || cmd.out_zero) begin
      done_r  <= 1'b1;
      okind_r <= kind_r;
      oid_r   <= id_r;
      olen_r  <= len_r;
    end
    if (cmd.out_data) begin
      obyte_r <= rdata_r;
      opos_r  <= emit_idx_r[4:0];
      olast_r <= sts.emit_last;
    end else if (cmd.out_zero) begin
      obyte_r <= 8'd0;
      opos_r  <= 5'd0;
      olast_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_done     = done_r;
  assign out_frame_kind_ack = okind_r;
  assign out_message_id     = oid_r;
  assign out_payload_length = olen_r;
  assign out_payload_byte   = obyte_r;
  assign out_byte_position  = opos_r;
  assign out_last_of_frame  = olast_r;

endmodule

// ----- sv/sync_length_checksum_deframer.sv -----
// Top level of the sync, length and checksum deframer with its register port.
//
//   Channel   Direction   Handshake               Contents
//   in_       input       in_valid / in_ready     one received byte per item
//   out_      output      out_valid / out_ready   one payload byte of a verified frame, or a zero byte for an empty one
//   APB       input       psel / penable          sync byte registers
//
// A received byte is taken in the cycle it arrives, while in_ready is high.
// After a verified checksum, input waits while the results are loaded; each passes S_RD
// and S_OUT for the registered payload memory read, or S_ZERO for an empty frame.
// A result waiting in the output register stalls the next one and so the input; once the
// last result of a frame is loaded, input resumes while that result still waits.
// Reset is synchronous and active low; it returns the block to hunting the first sync.
module sync_length_checksum_deframer
  import sldf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_done,
  output logic        out_frame_kind_ack,
  output logic [7:0]  out_message_id,
  output logic [5:0]  out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_byte_position,
  output logic        out_last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] first_sync_r;
  logic [7:0] sync2_data_r;
  logic [7:0] sync2_ack_r;
  logic       wr_en;
  sldf_cmd_t  cmd;
  sldf_sts_t  sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r <= FIRST_SYNC_RST;
      sync2_data_r <= SYNC2_DATA_RST;
      sync2_ack_r  <= SYNC2_ACK_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_FIRST_SYNC: first_sync_r <= pwdata[7:0];
        REG_SYNC2_DATA: sync2_data_r <= pwdata[7:0];
        REG_SYNC2_ACK:  sync2_ack_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST_SYNC: prdata = {24'd0, first_sync_r};
      REG_SYNC2_DATA: prdata = {24'd0, sync2_data_r};
      REG_SYNC2_ACK:  prdata = {24'd0, sync2_ack_r};
      default:        prdata = 32'd0;
    endcase
  end

  sldf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sldf_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_rx_byte         (in_rx_byte),
    .first_sync         (first_sync_r),
    .second_sync_data   (sync2_data_r),
    .second_sync_ack    (sync2_ack_r),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_done     (out_frame_done),
    .out_frame_kind_ack (out_frame_kind_ack),
    .out_message_id     (out_message_id),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_byte_position  (out_byte_position),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule
